// ===== rtl/itp_pkg.sv =====
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int CHAR_W      = 8;
    localparam int STATUS_W    = 2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNMATCHED = 2'd2;

    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

    // Letters and digits only; other characters, but '(', ')' and a finish, are handled as operators.
    function automatic logic is_operand(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic [1:0] prec_of(input logic [CHAR_W-1:0] c);
        logic [1:0] p;
        p = 2'd0;
        if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
        if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
        return p;
    endfunction

endpackage

// ===== rtl/itp_ram.sv =====
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/infix_to_postfix_converter.sv =====
// Channel   Direction  Transfer when              Payload
// s_axis    in         tvalid & tready            tdata = in_char, tlast = finish
// m_axis    out        tvalid & tready            tdata = out_char, tlast = expr_end,
//                                                 tuser = status
//
// An operand is sent through S_EMIT_CHAR and a '(' is pushed in S_PUSH. Each pop is a read
// of the top entry through the registered RAM port in S_RD and then the compare and
// transfer in S_CMP; an operator is pushed in S_PUSH after its pops. Reset is synchronous
// and active low and empties the stack; no clearing pass. The input is not ready while an
// item is at work. A stalled output holds the sequencer only at a step that needs a new
// result transfer.
module infix_to_postfix_converter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [itp_pkg::CHAR_W-1:0]    i_s_axis_tdata,   // [7:0] in_char
    input  logic                          i_s_axis_tlast,   // finish
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [itp_pkg::CHAR_W-1:0]    o_m_axis_tdata,   // [7:0] out_char
    output logic                          o_m_axis_tlast,   // expr_end
    output logic [itp_pkg::STATUS_W-1:0]  o_m_axis_tuser    // [1:0] status
);

    import itp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_RD        = 7'b0000010,
        S_CMP       = 7'b0000100,
        S_PUSH      = 7'b0001000,
        S_EMIT_CHAR = 7'b0010000,
        S_EMIT_END  = 7'b0100000,
        S_EMIT_UNM  = 7'b1000000
    } t_state;

    typedef enum logic [1:0] {
        M_DRAIN = 2'd0,
        M_CLOSE = 2'd1,
        M_OP    = 2'd2
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic [CHAR_W-1:0] r_char, n_char;
    logic [CNT_W-1:0]  r_count, n_count;

    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_out_char, n_out_char;
    logic                r_out_end, n_out_end;
    logic [STATUS_W-1:0] r_out_status, n_out_status;

    logic              w_out_free;
    logic              w_in_xfer;
    logic [CNT_W-1:0]  w_top_idx;
    logic [CHAR_W-1:0] w_top;
    logic              w_we;

    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_in_xfer  = i_s_axis_tvalid && (r_state == S_IDLE);
    assign w_top_idx  = r_count - CNT_W'(1);

    itp_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (r_char),
        .i_raddr (w_top_idx[ADDR_W-1:0]),
        .o_rdata (w_top)
    );

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_char       = r_char;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_char   = r_out_char;
        n_out_end    = r_out_end;
        n_out_status = r_out_status;
        w_we         = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_char = i_s_axis_tdata;
                    if (i_s_axis_tlast) begin
                        n_mode  = M_DRAIN;
                        n_state = S_RD;
                    end else if (is_operand(i_s_axis_tdata)) begin
                        n_state = S_EMIT_CHAR;
                    end else if (i_s_axis_tdata == CH_LPAREN) begin
                        n_state = S_PUSH;
                    end else if (i_s_axis_tdata == CH_RPAREN) begin
                        n_mode  = M_CLOSE;
                        n_state = S_RD;
                    end else begin
                        n_mode  = M_OP;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                // The RAM read of the top entry is under way this cycle.
                if (r_count == '0) begin
                    unique case (r_mode)
                        M_DRAIN: n_state = S_EMIT_END;
                        M_CLOSE: n_state = S_EMIT_UNM;
                        M_OP:    n_state = S_PUSH;
                        default: n_state = S_IDLE;
                    endcase
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_mode == M_CLOSE && w_top == CH_LPAREN) begin
                    n_count = w_top_idx;
                    n_state = S_IDLE;
                end else if (r_mode == M_OP && prec_of(r_char) > prec_of(w_top)) begin
                    n_state = S_PUSH;
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = w_top;
                    n_out_end    = 1'b0;
                    n_out_status = ST_OK;
                    n_count      = w_top_idx;
                    n_state      = S_RD;
                end
            end
            S_PUSH: begin
                if (r_count == CNT_W'(STACK_DEPTH)) begin
                    if (w_out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_char   = CH_NUL;
                        n_out_end    = 1'b0;
                        n_out_status = ST_OVERFLOW;
                        n_count      = '0;
                        n_state      = S_IDLE;
                    end
                end else begin
                    w_we    = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    n_state = S_IDLE;
                end
            end
            S_EMIT_CHAR: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = r_char;
                    n_out_end    = 1'b0;
                    n_out_status = ST_OK;
                    n_state      = S_IDLE;
                end
            end
            S_EMIT_END: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = CH_NUL;
                    n_out_end    = 1'b1;
                    n_out_status = ST_OK;
                    n_state      = S_IDLE;
                end
            end
            S_EMIT_UNM: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = CH_NUL;
                    n_out_end    = 1'b0;
                    n_out_status = ST_UNMATCHED;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= M_DRAIN;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char       <= n_char;
        r_out_char   <= n_out_char;
        r_out_end    <= n_out_end;
        r_out_status <= n_out_status;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_char;
    assign o_m_axis_tlast  = r_out_end;
    assign o_m_axis_tuser  = r_out_status;

endmodule
